@@ rtl/lph_pkg.sv @@
// Shared types, codes and widths for the linear probe hash table.
// No dependencies.
package lph_pkg;

   localparam int KEY_W   = 32;
   localparam int HASH_W  = 48;
   localparam int VAL_W   = 32;
   localparam int COUNT_W = 11;
   localparam int ACT_W   = 2;
   localparam int STAT_W  = 3;
   localparam int SLOT_W  = 2;

   localparam int DEF_CAPACITY = 1024;
   localparam logic [COUNT_W-1:0] LIMIT_RESET = 11'd819;

   localparam logic [ACT_W-1:0] ACT_INSERT = 2'd0;
   localparam logic [ACT_W-1:0] ACT_REMOVE = 2'd1;
   localparam logic [ACT_W-1:0] ACT_LOOKUP = 2'd2;
   localparam logic [ACT_W-1:0] ACT_CLEAR  = 2'd3;

   localparam logic [SLOT_W-1:0] SLOT_EMPTY = 2'd0;
   localparam logic [SLOT_W-1:0] SLOT_LIVE  = 2'd1;
   localparam logic [SLOT_W-1:0] SLOT_TOMB  = 2'd2;

   localparam logic [STAT_W-1:0] STAT_INSERTED = 3'd0;
   localparam logic [STAT_W-1:0] STAT_REPLACED = 3'd1;
   localparam logic [STAT_W-1:0] STAT_FOUND    = 3'd2;
   localparam logic [STAT_W-1:0] STAT_NOTFOUND = 3'd3;
   localparam logic [STAT_W-1:0] STAT_FULL     = 3'd4;
   localparam logic [STAT_W-1:0] STAT_CLEARED  = 3'd5;

   typedef struct packed {
      logic [SLOT_W-1:0] state;
      logic [KEY_W-1:0]  key;
      logic [HASH_W-1:0] hash;
      logic [VAL_W-1:0]  value;
   } entry_type;

endpackage

@@ rtl/linear_probe_hash_table.sv @@
// Linear probe hash table: a request goes through accept, home slot, one probe step
// per slot visited and finish; a new request is taken only in idle. A capacity that
// is not a power of two makes lph_home reduce the hash byte by byte. The probe loop
// reads one slot per cycle from lph_store. After reset a sweep empties every slot
// before the first request is taken. Uses lph_pkg, lph_home, lph_store.
module linear_probe_hash_table import lph_pkg::*; #(
   parameter int CAPACITY = DEF_CAPACITY
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   input  logic [111:0]        req_tdata,   // key_id, key_hash, value_in
   input  logic [ACT_W-1:0]    req_tuser,   // action
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   output logic [47:0]         rsp_tdata,   // value_out, entry_count, zero fill
   output logic [STAT_W-1:0]   rsp_tuser,   // status
   input  logic                csr_we,
   input  logic [COUNT_W-1:0]  csr_wdata
);

   localparam int IW = $clog2(CAPACITY);
   localparam int CW = $clog2(CAPACITY + 1);

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_HOME  = 3'd1;
   localparam logic [2:0] S_PROBE = 3'd2;
   localparam logic [2:0] S_DONE  = 3'd3;
   localparam logic [2:0] S_SWEEP = 3'd4;

   logic [2:0]         state_ff, state_in;
   logic [ACT_W-1:0]   act_ff, act_in;
   logic [KEY_W-1:0]   key_ff, key_in;
   logic [HASH_W-1:0]  hash_ff, hash_in;
   logic [VAL_W-1:0]   val_ff, val_in;
   logic [COUNT_W-1:0] limit_ff, limit_in;
   logic [COUNT_W-1:0] live_ff, live_in;
   logic [IW-1:0]      chk_ff, chk_in;
   logic [CW-1:0]      cnt_ff, cnt_in;
   logic               free_vld_ff, free_vld_in;
   logic [IW-1:0]      free_ff, free_in;
   logic [IW-1:0]      sweep_ff, sweep_in;
   logic               sweep_rsp_ff, sweep_rsp_in;
   logic [STAT_W-1:0]  res_stat_ff, res_stat_in;
   logic [VAL_W-1:0]   res_val_ff, res_val_in;
   logic               rsp_vld_ff, rsp_vld_in;
   logic [STAT_W-1:0]  rsp_stat_ff, rsp_stat_in;
   logic [VAL_W-1:0]   rsp_val_ff, rsp_val_in;
   logic [COUNT_W-1:0] rsp_cnt_ff, rsp_cnt_in;

   logic              accept;
   logic              home_start;
   logic              home_done;
   logic [IW-1:0]     home;
   logic              wr_en;
   logic [IW-1:0]     wr_addr;
   entry_type         wr_data;
   logic [IW-1:0]     rd_addr;
   entry_type         rd_data;
   logic [IW-1:0]     nxt_idx;
   logic              slot_live;
   logic              slot_empty;
   logic              slot_match;
   logic [CW-1:0]     cnt_nxt;
   logic              probe_end;
   logic              free_now;
   logic [IW-1:0]     free_idx;

   assign accept     = req_tvalid && req_tready;
   assign req_tready = (state_ff == S_IDLE);
   assign home_start = accept && (req_tuser != ACT_CLEAR);

   lph_home #(.CAPACITY(CAPACITY)) u_home (
      .clock (clock),
      .reset (reset),
      .start (home_start),
      .hash  (req_tdata[79:32]),
      .done  (home_done),
      .home  (home)
   );

   lph_store #(.CAPACITY(CAPACITY)) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign nxt_idx    = (chk_ff == IW'(CAPACITY - 1)) ? '0 : chk_ff + 1'b1;
   assign rd_addr    = (state_ff == S_HOME) ? home : nxt_idx;
   assign slot_live  = (rd_data.state == SLOT_LIVE);
   assign slot_empty = (rd_data.state == SLOT_EMPTY);
   assign slot_match = slot_live && (rd_data.key == key_ff) && (rd_data.hash == hash_ff);
   assign cnt_nxt    = cnt_ff + 1'b1;
   assign probe_end  = slot_match || slot_empty || (cnt_nxt == CW'(CAPACITY));
   assign free_now   = free_vld_ff || !slot_live;
   assign free_idx   = free_vld_ff ? free_ff : chk_ff;

   always_comb begin
      state_in     = state_ff;
      act_in       = act_ff;
      key_in       = key_ff;
      hash_in      = hash_ff;
      val_in       = val_ff;
      limit_in     = csr_we ? csr_wdata : limit_ff;
      live_in      = live_ff;
      chk_in       = chk_ff;
      cnt_in       = cnt_ff;
      free_vld_in  = free_vld_ff;
      free_in      = free_ff;
      sweep_in     = sweep_ff;
      sweep_rsp_in = sweep_rsp_ff;
      res_stat_in  = res_stat_ff;
      res_val_in   = res_val_ff;
      rsp_vld_in   = rsp_vld_ff && !rsp_tready;
      rsp_stat_in  = rsp_stat_ff;
      rsp_val_in   = rsp_val_ff;
      rsp_cnt_in   = rsp_cnt_ff;
      wr_en        = 1'b0;
      wr_addr      = chk_ff;
      wr_data      = '{state: SLOT_LIVE, key: key_ff, hash: hash_ff, value: val_ff};

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               act_in  = req_tuser;
               key_in  = req_tdata[31:0];
               hash_in = req_tdata[79:32];
               val_in  = req_tdata[111:80];
               if (req_tuser == ACT_CLEAR) begin
                  sweep_in     = '0;
                  sweep_rsp_in = 1'b1;
                  state_in     = S_SWEEP;
               end else begin
                  state_in = S_HOME;
               end
            end
         end
         S_HOME: begin
            if (home_done) begin
               chk_in      = home;
               cnt_in      = '0;
               free_vld_in = 1'b0;
               state_in    = S_PROBE;
            end
         end
         S_PROBE: begin
            chk_in = nxt_idx;
            cnt_in = cnt_nxt;
            if (!free_vld_ff && !slot_live) begin
               free_vld_in = 1'b1;
               free_in     = chk_ff;
            end
            if (probe_end) begin
               state_in    = S_DONE;
               res_stat_in = STAT_NOTFOUND;
               res_val_in  = '0;
               unique case (act_ff)
                  ACT_INSERT: begin
                     if (slot_match) begin
                        wr_en       = 1'b1;
                        res_stat_in = STAT_REPLACED;
                        res_val_in  = rd_data.value;
                     end else if ((live_ff >= limit_ff) || !free_now) begin
                        res_stat_in = STAT_FULL;
                     end else begin
                        wr_en       = 1'b1;
                        wr_addr     = free_idx;
                        live_in     = live_ff + 1'b1;
                        res_stat_in = STAT_INSERTED;
                     end
                  end
                  ACT_REMOVE: begin
                     if (slot_match) begin
                        wr_en         = 1'b1;
                        wr_data.state = SLOT_TOMB;
                        if (live_ff != '0) begin
                           live_in = live_ff - 1'b1;
                        end
                        res_stat_in = STAT_FOUND;
                        res_val_in  = rd_data.value;
                     end
                  end
                  ACT_LOOKUP: begin
                     if (slot_match) begin
                        res_stat_in = STAT_FOUND;
                        res_val_in  = rd_data.value;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_SWEEP: begin
            wr_en         = 1'b1;
            wr_addr       = sweep_ff;
            wr_data.state = SLOT_EMPTY;
            sweep_in      = sweep_ff + 1'b1;
            if (sweep_ff == IW'(CAPACITY - 1)) begin
               live_in     = '0;
               res_stat_in = STAT_CLEARED;
               res_val_in  = '0;
               state_in    = sweep_rsp_ff ? S_DONE : S_IDLE;
            end
         end
         S_DONE: begin
            if (!rsp_vld_ff || rsp_tready) begin
               rsp_vld_in  = 1'b1;
               rsp_stat_in = res_stat_ff;
               rsp_val_in  = res_val_ff;
               rsp_cnt_in  = live_ff;
               state_in    = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_SWEEP;
         sweep_ff     <= '0;
         sweep_rsp_ff <= 1'b0;
         limit_ff     <= LIMIT_RESET;
         live_ff      <= '0;
         rsp_vld_ff   <= 1'b0;
         cnt_ff       <= '0;
         free_vld_ff  <= 1'b0;
      end else begin
         state_ff     <= state_in;
         sweep_ff     <= sweep_in;
         sweep_rsp_ff <= sweep_rsp_in;
         limit_ff     <= limit_in;
         live_ff      <= live_in;
         rsp_vld_ff   <= rsp_vld_in;
         cnt_ff       <= cnt_in;
         free_vld_ff  <= free_vld_in;
      end
      act_ff      <= act_in;
      key_ff      <= key_in;
      hash_ff     <= hash_in;
      val_ff      <= val_in;
      chk_ff      <= chk_in;
      free_ff     <= free_in;
      res_stat_ff <= res_stat_in;
      res_val_ff  <= res_val_in;
      rsp_stat_ff <= rsp_stat_in;
      rsp_val_ff  <= rsp_val_in;
      rsp_cnt_ff  <= rsp_cnt_in;
   end

   assign rsp_tvalid = rsp_vld_ff;
   assign rsp_tuser  = rsp_stat_ff;
   assign rsp_tdata  = {5'd0, rsp_cnt_ff, rsp_val_ff};

`ifndef SYNTH
   a_live_bound: assert property (@(posedge clock) disable iff (reset)
      live_ff <= CAPACITY)
      else $error("live count above capacity");

   a_probe_write_ends: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_PROBE && wr_en) |=> state_ff == S_DONE)
      else $error("slot write without ending the probe");

   a_probe_bound: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_PROBE |-> cnt_ff < CAPACITY)
      else $error("probe ran past capacity");

   a_sweep_clears: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SWEEP && state_in != S_SWEEP) |=> live_ff == '0)
      else $error("live count not zero after sweep");
`endif

endmodule

@@ rtl/lph_home.sv @@
// Home slot unit: key_hash mod CAPACITY.
// Power-of-two capacity is a mask; otherwise one hash byte per cycle. Uses lph_pkg.
module lph_home import lph_pkg::*; #(
   parameter int CAPACITY = DEF_CAPACITY
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic [HASH_W-1:0]           hash,
   output logic                        done,
   output logic [$clog2(CAPACITY)-1:0] home
);

   localparam int IW = $clog2(CAPACITY);

   generate
      if ((CAPACITY & (CAPACITY - 1)) == 0) begin : g_mask
         logic          done_ff;
         logic [IW-1:0] home_ff;

         always_ff @(posedge clock) begin
            if (reset) begin
               done_ff <= 1'b0;
            end else begin
               done_ff <= start;
            end
            home_ff <= hash[IW-1:0];
         end

         assign done = done_ff;
         assign home = home_ff;
      end else begin : g_iter
         localparam int NCH = HASH_W / 8;
         localparam int NW  = $clog2(NCH + 1);
         localparam logic [IW:0] CAP_T = (IW + 1)'(CAPACITY);

         logic              run_ff, run_in;
         logic              done_ff, done_in;
         logic [NW-1:0]     cnt_ff, cnt_in;
         logic [HASH_W-1:0] hsh_ff, hsh_in;
         logic [IW-1:0]     rem_ff, rem_in;
         logic [IW-1:0]     step_r;

         always_comb begin
            logic [IW:0]   t;
            logic [IW-1:0] r;
            r = rem_ff;
            for (int j = 7; j >= 0; j--) begin
               t = {r, hsh_ff[HASH_W-8+j]};
               if (t >= CAP_T) begin
                  t = t - CAP_T;
               end
               r = t[IW-1:0];
            end
            step_r = r;
         end

         always_comb begin
            run_in  = run_ff;
            done_in = 1'b0;
            cnt_in  = cnt_ff;
            hsh_in  = hsh_ff;
            rem_in  = rem_ff;
            if (start) begin
               run_in = 1'b1;
               cnt_in = NW'(NCH);
               hsh_in = hash;
               rem_in = '0;
            end else if (run_ff) begin
               rem_in = step_r;
               hsh_in = {hsh_ff[HASH_W-9:0], 8'd0};
               cnt_in = cnt_ff - 1'b1;
               if (cnt_ff == NW'(1)) begin
                  run_in  = 1'b0;
                  done_in = 1'b1;
               end
            end
         end

         always_ff @(posedge clock) begin
            if (reset) begin
               run_ff  <= 1'b0;
               done_ff <= 1'b0;
               cnt_ff  <= '0;
            end else begin
               run_ff  <= run_in;
               done_ff <= done_in;
               cnt_ff  <= cnt_in;
            end
            hsh_ff <= hsh_in;
            rem_ff <= rem_in;
         end

         assign done = done_ff;
         assign home = rem_ff;
      end
   endgenerate

endmodule

@@ rtl/lph_store.sv @@
// Slot memory: state, key, hash and value per slot.
// One write port, one registered read port. Uses lph_pkg.
module lph_store import lph_pkg::*; #(
   parameter int CAPACITY = DEF_CAPACITY
) (
   input  logic                        clock,
   input  logic                        wr_en,
   input  logic [$clog2(CAPACITY)-1:0] wr_addr,
   input  entry_type                   wr_data,
   input  logic [$clog2(CAPACITY)-1:0] rd_addr,
   output entry_type                   rd_data
);

   entry_type mem [CAPACITY];
   entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ sim/tb_top.sv @@
// Testbench for linear_probe_hash_table: directed and random insert, remove, lookup
// and clear requests checked against a behavioral mirror of the table.
// Depends on lph_pkg and the RTL of linear_probe_hash_table.
`timescale 1ns / 100ps

module tb_top;
   import lph_pkg::*;

   localparam int CAP = DEF_CAPACITY;
   localparam int HOME_W = $clog2(CAP);
   localparam int POOL = 40;
   localparam int RSP_HOLD_CYCLES = 400;
   localparam int LIMIT_CYCLES = 2000000;

   typedef struct packed {
      logic [STAT_W-1:0]  status;
      logic [VAL_W-1:0]   value;
      logic [COUNT_W-1:0] count;
   } table_result_type;

   logic                clock;
   logic                reset = 1'b1;
   logic                req_tvalid = 1'b0;
   logic                req_tready;
   logic [111:0]        req_tdata = '0;
   logic [ACT_W-1:0]    req_tuser = ACT_LOOKUP;
   logic                rsp_tvalid;
   logic                rsp_tready = 1'b0;
   logic [47:0]         rsp_tdata;
   logic [STAT_W-1:0]   rsp_tuser;
   logic                csr_we = 1'b0;
   logic [COUNT_W-1:0]  csr_wdata = '0;

   logic [SLOT_W-1:0]   mirror_state [CAP];
   logic [KEY_W-1:0]    mirror_key   [CAP];
   logic [HASH_W-1:0]   mirror_hash  [CAP];
   logic [VAL_W-1:0]    mirror_value [CAP];
   int                  mirror_live;
   int                  mirror_limit;

   table_result_type    pending_results [$];
   int                  mismatch_count = 0;
   int                  cycle_count = 0;
   bit                  req_idle_en = 1'b1;
   bit                  rsp_idle_en = 1'b1;
   bit                  rsp_hold_pending = 1'b0;

   linear_probe_hash_table dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > LIMIT_CYCLES) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("CHECKS FAILED");
         $finish;
      end
   end

   // ---------------- table mirror ----------------

   function automatic bit mirror_find_key(input logic [KEY_W-1:0] key,
                                          input logic [HASH_W-1:0] hash, output int slot);
      int idx;
      idx = int'(hash % HASH_W'(CAP));
      slot = 0;
      for (int n = 0; n < CAP; n++) begin
         if (mirror_state[idx] == SLOT_EMPTY)
            return 1'b0;
         if (mirror_state[idx] == SLOT_LIVE && mirror_key[idx] == key &&
             mirror_hash[idx] == hash) begin
            slot = idx;
            return 1'b1;
         end
         idx = (idx + 1 >= CAP) ? 0 : idx + 1;
      end
      return 1'b0;
   endfunction

   function automatic bit mirror_find_free(input logic [HASH_W-1:0] hash, output int slot);
      int idx;
      idx = int'(hash % HASH_W'(CAP));
      slot = 0;
      for (int n = 0; n < CAP; n++) begin
         if (mirror_state[idx] != SLOT_LIVE) begin
            slot = idx;
            return 1'b1;
         end
         idx = (idx + 1 >= CAP) ? 0 : idx + 1;
      end
      return 1'b0;
   endfunction

   function automatic table_result_type mirror_apply(input logic [ACT_W-1:0] act,
                                                     input logic [KEY_W-1:0] key,
                                                     input logic [HASH_W-1:0] hash,
                                                     input logic [VAL_W-1:0] val);
      table_result_type r;
      int slot;
      bit hit;
      bit room;
      r.status = STAT_NOTFOUND;
      r.value = '0;
      hit = mirror_find_key(key, hash, slot);
      case (act)
         ACT_INSERT: begin
            if (hit) begin
               r.value = mirror_value[slot];
               mirror_value[slot] = val;
               r.status = STAT_REPLACED;
            end else if (mirror_live >= mirror_limit) begin
               r.status = STAT_FULL;
            end else begin
               room = mirror_find_free(hash, slot);
               if (!room) begin
                  r.status = STAT_FULL;
               end else begin
                  mirror_state[slot] = SLOT_LIVE;
                  mirror_key[slot] = key;
                  mirror_hash[slot] = hash;
                  mirror_value[slot] = val;
                  mirror_live++;
                  r.status = STAT_INSERTED;
               end
            end
         end
         ACT_REMOVE: begin
            if (hit) begin
               r.value = mirror_value[slot];
               mirror_state[slot] = SLOT_TOMB;
               if (mirror_live > 0)
                  mirror_live--;
               r.status = STAT_FOUND;
            end
         end
         ACT_LOOKUP: begin
            if (hit) begin
               r.value = mirror_value[slot];
               r.status = STAT_FOUND;
            end
         end
         default: begin
            foreach (mirror_state[i])
               mirror_state[i] = SLOT_EMPTY;
            mirror_live = 0;
            r.status = STAT_CLEARED;
         end
      endcase
      r.count = COUNT_W'(mirror_live);
      return r;
   endfunction

   function automatic logic [HASH_W-1:0] random_hash();
      return HASH_W'({$urandom, $urandom});
   endfunction

   // ---------------- response side ----------------

   task automatic report_mismatch(input string what, input logic [63:0] got,
                                  input logic [63:0] want);
      $display("mismatch %s: got %0h expected %0h (cycle %0d)",
               what, got, want, cycle_count);
      mismatch_count++;
   endtask

   initial begin
      forever begin
         @(posedge clock);
         if (rsp_hold_pending) begin
            rsp_hold_pending = 1'b0;
            rsp_tready <= 1'b0;
            repeat (RSP_HOLD_CYCLES) @(posedge clock);
         end
         rsp_tready <= !(rsp_idle_en && $urandom_range(99) < 37);
      end
   end

   always @(posedge clock) begin
      table_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_results.size() == 0) begin
            report_mismatch("unexpected response", 64'(rsp_tdata), 64'(rsp_tuser));
         end else begin
            want = pending_results.pop_front();
            if (rsp_tuser !== want.status)
               report_mismatch("status", 64'(rsp_tuser), 64'(want.status));
            if (rsp_tdata[31:0] !== want.value)
               report_mismatch("value_out", 64'(rsp_tdata[31:0]), 64'(want.value));
            if (rsp_tdata[42:32] !== want.count)
               report_mismatch("entry_count", 64'(rsp_tdata[42:32]), 64'(want.count));
         end
      end
   end

   // ---------------- request side ----------------

   task automatic send_request(input logic [ACT_W-1:0] act, input logic [KEY_W-1:0] key,
                               input logic [HASH_W-1:0] hash, input logic [VAL_W-1:0] val);
      while (req_idle_en && $urandom_range(99) < 37) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= act;
      req_tdata <= {val, hash, key};
      @(posedge clock);
      while (!req_tready)
         @(posedge clock);
      pending_results.push_back(mirror_apply(act, key, hash, val));
   endtask

   task automatic wait_for_results();
      req_tvalid <= 1'b0;
      while (pending_results.size() != 0)
         @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_load_limit(input logic [COUNT_W-1:0] lim);
      wait_for_results();
      csr_we <= 1'b1;
      csr_wdata <= lim;
      @(posedge clock);
      csr_we <= 1'b0;
      mirror_limit = int'(lim);
   endtask

   // ---------------- tests ----------------

   // Reset limit: replace, wrap from the last slot, key must match with its hash,
   // lookup past a tombstone, tombstone reuse, key zero, clear.
   task automatic test_basic_ops();
      send_request(ACT_LOOKUP, 32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF, 32'h0);
      send_request(ACT_REMOVE, 32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF, 32'h0);
      send_request(ACT_INSERT, 32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF, 32'hFFFF_FFFF);
      send_request(ACT_INSERT, 32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF, 32'h0);
      send_request(ACT_INSERT, 32'h1, 48'h0000_0000_03FF, 32'h1234_5678);
      send_request(ACT_LOOKUP, 32'h1, 48'h0000_0000_03FF, 32'h0);
      send_request(ACT_LOOKUP, 32'hFFFF_FFFF, 48'h0000_0000_03FF, 32'h0);
      send_request(ACT_REMOVE, 32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF, 32'h0);
      send_request(ACT_LOOKUP, 32'h1, 48'h0000_0000_03FF, 32'h0);
      send_request(ACT_INSERT, 32'h0, 48'h0, 32'hA5A5_A5A5);
      send_request(ACT_LOOKUP, 32'h0, 48'h0, 32'h0);
      send_request(ACT_INSERT, 32'h8000_0000, 48'h8000_0000_03FF, 32'h5A5A_5A5A);
      send_request(ACT_REMOVE, 32'h0, 48'h0, 32'h0);
      send_request(ACT_LOOKUP, 32'h0, 48'h0, 32'h0);
      send_request(ACT_CLEAR, 32'h0, 48'h0, 32'h0);
      send_request(ACT_LOOKUP, 32'h1, 48'h0000_0000_03FF, 32'h0);
   endtask

   task automatic test_load_limits();
      write_load_limit(11'd1);
      send_request(ACT_INSERT, 32'h11, 48'h1_0000_0010, 32'h1);
      send_request(ACT_INSERT, 32'h22, 48'h2_0000_0011, 32'h2);
      send_request(ACT_INSERT, 32'h11, 48'h1_0000_0010, 32'h3);
      send_request(ACT_REMOVE, 32'h11, 48'h1_0000_0010, 32'h0);
      send_request(ACT_INSERT, 32'h22, 48'h2_0000_0011, 32'h4);
      write_load_limit(11'd0);
      send_request(ACT_INSERT, 32'h11, 48'h1_0000_0010, 32'h5);
      send_request(ACT_INSERT, 32'h22, 48'h2_0000_0011, 32'h6);
      send_request(ACT_CLEAR, 32'h0, 48'h0, 32'h0);
      send_request(ACT_INSERT, 32'h22, 48'h2_0000_0011, 32'h7);
      send_request(ACT_LOOKUP, 32'h22, 48'h2_0000_0011, 32'h0);
   endtask

   // Every slot live: insert with no free slot, search over the whole table,
   // tombstone refill at a limit of exactly the capacity, then refusal by limit.
   task automatic test_full_table();
      logic [HASH_W-1:0] hash;
      logic [HASH_W-1:0] kept_hash;
      logic [KEY_W-1:0]  key;
      logic [KEY_W-1:0]  kept_key;
      write_load_limit(11'd2047);
      req_idle_en = 1'b0;
      rsp_idle_en = 1'b0;
      send_request(ACT_CLEAR, $urandom, random_hash(), $urandom);
      kept_key = '0;
      kept_hash = '0;
      for (int i = 0; i < CAP; i++) begin
         hash = random_hash();
         hash[HOME_W-1:0] = HOME_W'(i);
         key = $urandom;
         if (i == CAP / 2 + 5) begin
            kept_key = key;
            kept_hash = hash;
         end
         send_request(ACT_INSERT, key, hash, $urandom);
      end
      req_idle_en = 1'b1;
      rsp_idle_en = 1'b1;
      send_request(ACT_INSERT, $urandom, random_hash(), $urandom);
      send_request(ACT_LOOKUP, $urandom, random_hash(), $urandom);
      send_request(ACT_LOOKUP, kept_key, kept_hash, $urandom);
      send_request(ACT_REMOVE, kept_key, kept_hash, $urandom);
      write_load_limit(11'd1024);
      send_request(ACT_INSERT, $urandom, random_hash(), $urandom);
      send_request(ACT_INSERT, $urandom, random_hash(), $urandom);
      send_request(ACT_CLEAR, $urandom, random_hash(), $urandom);
   endtask

   // Keys from a small pool homed in a narrow window, so chains, tombstones and
   // replacements are common; a share of unrelated requests and rare clears.
   task automatic test_random_traffic(input logic [COUNT_W-1:0] lim, input int n_items,
                                      input bit hold_output);
      logic [KEY_W-1:0]  pool_key  [POOL];
      logic [HASH_W-1:0] pool_hash [POOL];
      logic [ACT_W-1:0]  act;
      int base;
      int pick;
      int r;
      write_load_limit(lim);
      base = ($urandom_range(3) == 0) ? CAP - 8 : int'($urandom_range(CAP - 1));
      for (int i = 0; i < POOL; i++) begin
         pool_key[i] = (i > 0 && $urandom_range(9) == 0) ? pool_key[i-1] : $urandom;
         if ($urandom_range(19) == 0)
            pool_key[i] = '0;
         pool_hash[i] = random_hash();
         pool_hash[i][HOME_W-1:0] = HOME_W'((base + int'($urandom_range(15))) % CAP);
      end
      if (hold_output)
         rsp_hold_pending = 1'b1;
      repeat (n_items) begin
         r = $urandom_range(99);
         pick = $urandom_range(POOL - 1);
         if (r < 2) begin
            send_request(ACT_CLEAR, $urandom, random_hash(), $urandom);
         end else if (r < 14) begin
            send_request(ACT_W'($urandom_range(2)), $urandom, random_hash(), $urandom);
         end else begin
            act = (r < 54) ? ACT_INSERT : (r < 72) ? ACT_REMOVE : ACT_LOOKUP;
            send_request(act, pool_key[pick], pool_hash[pick], $urandom);
         end
         if ($urandom_range(199) == 0)
            wait_for_results();
      end
   endtask

   initial begin
      foreach (mirror_state[i]) begin
         mirror_state[i] = SLOT_EMPTY;
         mirror_key[i] = '0;
         mirror_hash[i] = '0;
         mirror_value[i] = '0;
      end
      mirror_live = 0;
      mirror_limit = int'(LIMIT_RESET);
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      test_basic_ops();
      test_load_limits();
      test_full_table();
      test_random_traffic(11'd819, 300, 1'b1);
      test_random_traffic(11'd8, 200, 1'b0);
      test_random_traffic(11'd1, 100, 1'b0);
      test_random_traffic(11'd0, 60, 1'b0);
      test_random_traffic(11'd2047, 300, 1'b1);
      test_random_traffic(11'd40, 200, 1'b0);

      wait_for_results();
      repeat (64) @(posedge clock);
      if (mismatch_count == 0 && pending_results.size() == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
